FILE: rtl/bepc_pkg.sv
// ----------------------------------------------------------------------------
// Beam event classifier package
// Word types, channel map, thresholds and codes shared by the classifier.
// ----------------------------------------------------------------------------
package bepc_pkg;

	typedef struct packed {
		logic               op;
		logic [5:0]         channel;
		logic signed [23:0] sample_value;
		logic               last_hit;
	} hit_word_t;

	typedef struct packed {
		logic [1:0]         particle_code;
		logic signed [31:0] flight_time_x4;
		logic signed [31:0] act_charge_sum;
	} result_word_t;

	typedef struct packed {
		logic               trigger;
		logic               veto_a;
		logic               veto_b;
		logic               times_ok;
		logic signed [31:0] act_sum;
		logic signed [31:0] up_sum;
		logic signed [31:0] dn_sum;
	} evt_sum_t;

	localparam logic OP_CHARGE = 1'b0;
	localparam logic OP_TIME   = 1'b1;

	localparam logic [5:0] CH_TRIG_A    = 6'd42;
	localparam logic [5:0] CH_TRIG_B    = 6'd43;
	localparam logic [5:0] CH_VETO_A    = 6'd9;
	localparam logic [5:0] CH_VETO_B    = 6'd10;
	localparam logic [5:0] CH_ACT_FIRST = 6'd18;
	localparam logic [5:0] CH_ACT_LAST  = 6'd23;
	localparam logic [5:0] CH_UP_LAST   = 6'd3;
	localparam logic [5:0] CH_DN_LAST   = 6'd7;

	localparam logic signed [23:0] TRIG_FX     = 24'sd4800;
	localparam logic signed [23:0] VETO_A_FX   = 24'sd2400;
	localparam logic signed [23:0] VETO_B_FX   = 24'sd1600;
	localparam logic signed [24:0] BASELINE_FX = 25'sd4000;
	localparam logic signed [24:0] EARLY_FX    = -25'sd1600;

	localparam logic [2:0] COUNT_GOOD = 3'd4;
	localparam logic [2:0] COUNT_MAX  = 3'd7;

	localparam logic [1:0] PCODE_NONE     = 2'd0;
	localparam logic [1:0] PCODE_ELECTRON = 2'd1;
	localparam logic [1:0] PCODE_MUON     = 2'd2;
	localparam logic [1:0] PCODE_PION     = 2'd3;

	localparam logic [2:0] REG_ELECTRON_TOF = 3'd0;
	localparam logic [2:0] REG_ELECTRON_ACT = 3'd1;
	localparam logic [2:0] REG_MUON_TOF     = 3'd2;
	localparam logic [2:0] REG_MUON_ACT     = 3'd3;
	localparam logic [2:0] REG_PION_TOF     = 3'd4;
	localparam logic [2:0] REG_PION_ACT     = 3'd5;
	localparam logic [2:0] REG_CUTS_LOADED  = 3'd6;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
		if (s[32] != s[31]) begin
			sat32 = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			sat32 = s[31:0];
		end
	endfunction

endpackage

FILE: rtl/beam_event_particle_classifier.sv
// ----------------------------------------------------------------------------
// Beam event particle classifier
// Accumulates the hits of one beam event and classifies it on the last hit.
// ----------------------------------------------------------------------------
// Takes one hit word per cycle with no gaps needed between hits or events,
// set by the saturating accumulate on the input register; a hit with the
// last mark waits there under res_ready back-pressure. Hits without the
// last mark produce nothing; a hit with the last mark produces one result
// word through the input, event summary, flight-time and result registers,
// and the event state is cleared for the next hit. The user must write cut
// windows and cuts_loaded through the cfg port only while no event result
// is pending; the block itself does not enforce this.
module beam_event_particle_classifier (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    hit_valid,
	output logic                    hit_ready,
	input  bepc_pkg::hit_word_t     hit,
	output logic                    res_valid,
	input  logic                    res_ready,
	output bepc_pkg::result_word_t  res,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [63:0]             cfg_data
);

	logic [63:0] e_tof_q, e_act_q, m_tof_q, m_act_q, p_tof_q, p_act_q;
	logic        cuts_q;

	logic                   valid_s1, valid_s2, valid_s3, res_valid_q;
	bepc_pkg::hit_word_t    hit_s1;
	bepc_pkg::evt_sum_t     evt_s2, summary;
	logic signed [31:0]     ftx4_s3, act_s3;
	logic                   elig_s3;
	bepc_pkg::result_word_t res_q;

	logic               take_out, take3, take2, take1, adv3, adv2, adv1;
	logic signed [31:0] ftx4_n;
	logic [1:0]         code_n;

	function automatic logic tof_in(input logic signed [31:0] v, input logic [63:0] win);
		logic signed [33:0] lo4, hi4, vx;
		lo4 = {win[31:0], 2'b00};
		hi4 = {win[63:32], 2'b00};
		vx  = {v[31], v[31], v};
		tof_in = vx >= lo4 && vx <= hi4;
	endfunction

	function automatic logic act_in(input logic signed [31:0] v, input logic [63:0] win);
		logic signed [31:0] lo, hi;
		lo = win[31:0];
		hi = win[63:32];
		act_in = v >= lo && v <= hi;
	endfunction

	assign take_out  = !res_valid_q || res_ready;
	assign adv3      = valid_s3 && take_out;
	assign take3     = !valid_s3 || take_out;
	assign adv2      = valid_s2 && take3;
	assign take2     = !valid_s2 || take3;
	assign adv1      = valid_s1 && (!hit_s1.last_hit || take2);
	assign take1     = !valid_s1 || adv1;
	assign hit_ready = take1;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	bepc_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.hit     (hit_s1),
		.fire    (adv1),
		.summary (summary)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_tof_q <= '0;
			e_act_q <= '0;
			m_tof_q <= '0;
			m_act_q <= '0;
			p_tof_q <= '0;
			p_act_q <= '0;
			cuts_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bepc_pkg::REG_ELECTRON_TOF: e_tof_q <= cfg_data;
				bepc_pkg::REG_ELECTRON_ACT: e_act_q <= cfg_data;
				bepc_pkg::REG_MUON_TOF:     m_tof_q <= cfg_data;
				bepc_pkg::REG_MUON_ACT:     m_act_q <= cfg_data;
				bepc_pkg::REG_PION_TOF:     p_tof_q <= cfg_data;
				bepc_pkg::REG_PION_ACT:     p_act_q <= cfg_data;
				bepc_pkg::REG_CUTS_LOADED:  cuts_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ftx4_n = evt_s2.times_ok
			? bepc_pkg::sat32({evt_s2.dn_sum[31], evt_s2.dn_sum}
				- {evt_s2.up_sum[31], evt_s2.up_sum})
			: '0;
		code_n = bepc_pkg::PCODE_NONE;
		if (elig_s3 && cuts_q) begin
			if (tof_in(ftx4_s3, e_tof_q) && act_in(act_s3, e_act_q)) begin
				code_n = bepc_pkg::PCODE_ELECTRON;
			end else if (tof_in(ftx4_s3, m_tof_q) && act_in(act_s3, m_act_q)) begin
				code_n = bepc_pkg::PCODE_MUON;
			end else if (tof_in(ftx4_s3, p_tof_q) && act_in(act_s3, p_act_q)) begin
				code_n = bepc_pkg::PCODE_PION;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take1) valid_s1 <= hit_valid;
			if (take2) valid_s2 <= adv1 && hit_s1.last_hit;
			if (take3) valid_s3 <= adv2;
			if (take_out) res_valid_q <= adv3;
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && hit_valid) hit_s1 <= hit;
		if (take2 && adv1 && hit_s1.last_hit) evt_s2 <= summary;
		if (adv2) begin
			ftx4_s3 <= ftx4_n;
			act_s3  <= evt_s2.act_sum;
			elig_s3 <= evt_s2.times_ok && evt_s2.trigger && !evt_s2.veto_a
				&& !evt_s2.veto_b && !evt_s2.act_sum[31];
		end
		if (adv3) begin
			res_q.particle_code  <= code_n;
			res_q.flight_time_x4 <= ftx4_s3;
			res_q.act_charge_sum <= act_s3;
		end
	end

	a_code_needs_cuts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.particle_code != bepc_pkg::PCODE_NONE |-> cuts_q)
		else $error("particle code without loaded cuts");

	a_code_needs_charge: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.particle_code != bepc_pkg::PCODE_NONE |-> !res.act_charge_sum[31])
		else $error("particle code with negative ACT sum");

	a_plain_hit_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !hit_s1.last_hit |-> adv1)
		else $error("non-last hit word held in input register");

	a_result_follows_s3: assert property (@(posedge clk) disable iff (!arst_n)
		adv3 |=> res_valid)
		else $error("result register did not load");

endmodule

FILE: rtl/bepc_accum.sv
// ----------------------------------------------------------------------------
// Beam event accumulator
// Per-event flags, saturating ACT and timing sums and early hit counts.
// ----------------------------------------------------------------------------
module bepc_accum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bepc_pkg::hit_word_t  hit,
	input  logic                 fire,
	output bepc_pkg::evt_sum_t   summary
);

	logic               trigger_q, veto_a_q, veto_b_q;
	logic signed [31:0] act_q, up_sum_q, dn_sum_q;
	logic [2:0]         up_cnt_q, dn_cnt_q;

	logic               is_charge, early, act_hit, up_hit, dn_hit;
	logic signed [24:0] t_rel;
	logic signed [32:0] act_add, up_add, dn_add;
	logic               trig_n, veto_a_n, veto_b_n;
	logic signed [31:0] act_n, up_sum_n, dn_sum_n;
	logic [2:0]         up_cnt_n, dn_cnt_n;

	always_comb begin
		is_charge = hit.op == bepc_pkg::OP_CHARGE;
		t_rel     = {hit.sample_value[23], hit.sample_value} - bepc_pkg::BASELINE_FX;
		early     = !is_charge && (t_rel < bepc_pkg::EARLY_FX);
		act_hit   = is_charge && hit.channel >= bepc_pkg::CH_ACT_FIRST
			&& hit.channel <= bepc_pkg::CH_ACT_LAST;
		up_hit    = early && hit.channel <= bepc_pkg::CH_UP_LAST;
		dn_hit    = early && hit.channel > bepc_pkg::CH_UP_LAST
			&& hit.channel <= bepc_pkg::CH_DN_LAST;

		trig_n   = trigger_q || (is_charge && (hit.channel == bepc_pkg::CH_TRIG_A
			|| hit.channel == bepc_pkg::CH_TRIG_B) && hit.sample_value > bepc_pkg::TRIG_FX);
		veto_a_n = veto_a_q || (is_charge && hit.channel == bepc_pkg::CH_VETO_A
			&& hit.sample_value > bepc_pkg::VETO_A_FX);
		veto_b_n = veto_b_q || (is_charge && hit.channel == bepc_pkg::CH_VETO_B
			&& hit.sample_value > bepc_pkg::VETO_B_FX);

		act_add = {act_q[31], act_q} + {{9{hit.sample_value[23]}}, hit.sample_value};
		up_add  = {up_sum_q[31], up_sum_q} + {{8{t_rel[24]}}, t_rel};
		dn_add  = {dn_sum_q[31], dn_sum_q} + {{8{t_rel[24]}}, t_rel};

		act_n    = act_hit ? bepc_pkg::sat32(act_add) : act_q;
		up_sum_n = up_hit ? bepc_pkg::sat32(up_add) : up_sum_q;
		dn_sum_n = dn_hit ? bepc_pkg::sat32(dn_add) : dn_sum_q;
		up_cnt_n = (up_hit && up_cnt_q != bepc_pkg::COUNT_MAX) ? up_cnt_q + 3'd1 : up_cnt_q;
		dn_cnt_n = (dn_hit && dn_cnt_q != bepc_pkg::COUNT_MAX) ? dn_cnt_q + 3'd1 : dn_cnt_q;

		summary.trigger  = trig_n;
		summary.veto_a   = veto_a_n;
		summary.veto_b   = veto_b_n;
		summary.times_ok = up_cnt_n == bepc_pkg::COUNT_GOOD && dn_cnt_n == bepc_pkg::COUNT_GOOD;
		summary.act_sum  = act_n;
		summary.up_sum   = up_sum_n;
		summary.dn_sum   = dn_sum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= 1'b0;
			veto_a_q  <= 1'b0;
			veto_b_q  <= 1'b0;
			act_q     <= '0;
			up_sum_q  <= '0;
			dn_sum_q  <= '0;
			up_cnt_q  <= '0;
			dn_cnt_q  <= '0;
		end else if (fire) begin
			if (hit.last_hit) begin
				// clear for the next event
				trigger_q <= 1'b0;
				veto_a_q  <= 1'b0;
				veto_b_q  <= 1'b0;
				act_q     <= '0;
				up_sum_q  <= '0;
				dn_sum_q  <= '0;
				up_cnt_q  <= '0;
				dn_cnt_q  <= '0;
			end else begin
				trigger_q <= trig_n;
				veto_a_q  <= veto_a_n;
				veto_b_q  <= veto_b_n;
				act_q     <= act_n;
				up_sum_q  <= up_sum_n;
				dn_sum_q  <= dn_sum_n;
				up_cnt_q  <= up_cnt_n;
				dn_cnt_q  <= dn_cnt_n;
			end
		end
	end

endmodule
